/* design/tofp_pkg.sv */
// ----------------------------------------------------------------------------
// tofp_pkg
// Shared types and constants of the depth-sensor result frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tofp_pkg;

    localparam int unsigned HDR_LEN     = 21;
    localparam int unsigned FOOTER_LEN  = 12;
    localparam int unsigned MIN_PAYLOAD = 24;
    localparam int unsigned POS_ID      = 5;
    localparam int unsigned POS_LAYOUT  = 6;
    localparam int unsigned POS_LEN_LO  = 7;
    localparam int unsigned POS_LEN_HI  = 8;

    localparam logic [15:0] END_MARK    = 16'hE0F7;
    localparam logic [3:0]  FRAME_ID    = 4'h1;
    localparam logic [3:0]  LAYOUT_CONF = 4'h1;
    localparam logic [10:0] COUNT_MAX   = 11'd2047;

    typedef enum logic [1:0] {
        WSEL_8  = 2'd0,
        WSEL_16 = 2'd1,
        WSEL_32 = 2'd2
    } t_wsel;

    typedef enum logic {
        KIND_PIXEL  = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ID  = 2'd1,
        ST_BAD_END = 2'd2,
        ST_BAD_LEN = 2'd3
    } t_status;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [10:0] grid_index;
        logic [13:0] dist_mm;
        logic [7:0]  confidence;
        t_status     frame_status;
        logic [10:0] pixel_count;
        logic        frame_complete;
        logic        odd_subframe;
    } t_result;

endpackage

`default_nettype wire

/* design/tofp_parser.sv */
// ----------------------------------------------------------------------------
// tofp_parser
// Frame state and per-word decode: header checks, pixel assembly, grid
// index mapping and the end-of-frame status.
// ----------------------------------------------------------------------------
`default_nettype none

module tofp_parser #(
    parameter int unsigned MAX_ZONES = 1536
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_start,
    input  wire logic [1:0]        i_width_sel,
    output tofp_pkg::t_result      o_res
);

    localparam logic [11:0] ZONE_LIMIT = 12'(MAX_ZONES);

    logic [4:0]  r_byte_pos, n_byte_pos;
    logic [7:0]  r_layout, n_layout;
    logic [15:0] r_payload, n_payload;
    logic [4:0]  r_pix_bytes, n_pix_bytes;
    logic [4:0]  r_bip, n_bip;
    logic [23:0] r_asm, n_asm;
    logic [10:0] r_sidx, n_sidx;
    logic [10:0] r_count, n_count;
    logic [15:0] r_ems, n_ems;
    logic        r_aborted, n_aborted;

    always_comb begin
        logic        odd;
        logic [15:0] payload;
        logic [5:0]  size;
        logic [4:0]  bip_inc;
        logic [11:0] idx;
        logic        full;

        n_byte_pos  = r_byte_pos;
        n_layout    = r_layout;
        n_payload   = r_payload;
        n_pix_bytes = r_pix_bytes;
        n_bip       = r_bip;
        n_asm       = r_asm;
        n_sidx      = r_sidx;
        n_count     = r_count;
        n_ems       = r_ems;
        n_aborted   = r_aborted;
        o_res       = '0;
        odd         = (r_layout[7:4] != 4'h0);
        payload     = {i_byte, r_payload[7:0]};
        size        = 6'(r_layout[2:0]) * (r_layout[3] ? 6'd5 : 6'd3);
        bip_inc     = '0;
        idx         = '0;
        full        = 1'b0;

        case (i_width_sel)
            tofp_pkg::WSEL_16: full = (r_count == 11'd256);
            tofp_pkg::WSEL_32: full = (r_count == 11'd1024);
            default:           full = (r_count == 11'd64);
        endcase

        if (i_vld) begin
            if (i_start) begin
                n_aborted  = 1'b0;
                n_byte_pos = '0;
                n_bip      = '0;
                n_asm      = '0;
                n_sidx     = '0;
                n_ems      = '0;
            end

            if (!n_aborted) begin
                if (n_byte_pos < 5'(tofp_pkg::HDR_LEN)) begin
                    n_byte_pos = n_byte_pos + 5'd1;
                    if (n_byte_pos == 5'(tofp_pkg::POS_ID + 1)) begin
                        if (i_byte[7:4] != tofp_pkg::FRAME_ID) begin
                            o_res.valid          = 1'b1;
                            o_res.kind           = tofp_pkg::KIND_STATUS;
                            o_res.frame_status   = tofp_pkg::ST_BAD_ID;
                            o_res.pixel_count    = r_count;
                            o_res.odd_subframe   = 1'b0;
                            n_aborted            = 1'b1;
                        end
                    end else if (n_byte_pos == 5'(tofp_pkg::POS_LAYOUT + 1)) begin
                        n_layout = i_byte;
                        if (i_byte[7:4] == 4'h0) begin
                            n_count = '0;
                        end
                    end else if (n_byte_pos == 5'(tofp_pkg::POS_LEN_LO + 1)) begin
                        n_payload = {8'h00, i_byte};
                    end else if (n_byte_pos == 5'(tofp_pkg::POS_LEN_HI + 1)) begin
                        if (payload < 16'(tofp_pkg::MIN_PAYLOAD) || size == 6'd0
                                || size > 6'd31) begin
                            o_res.valid        = 1'b1;
                            o_res.kind         = tofp_pkg::KIND_STATUS;
                            o_res.frame_status = tofp_pkg::ST_BAD_LEN;
                            o_res.pixel_count  = r_count;
                            o_res.odd_subframe = odd;
                            n_aborted          = 1'b1;
                        end else begin
                            n_payload   = payload - 16'(tofp_pkg::FOOTER_LEN);
                            n_pix_bytes = size[4:0];
                        end
                    end
                end else begin
                    n_ems = {i_byte, n_ems[15:8]};
                    if (r_payload > 16'(tofp_pkg::FOOTER_LEN)) begin
                        if (n_bip == 5'd0) begin
                            n_asm = '0;
                        end
                        case (n_bip)
                            5'd0:    n_asm[7:0]   = i_byte;
                            5'd1:    n_asm[15:8]  = i_byte;
                            5'd2:    n_asm[23:16] = i_byte;
                            default: n_asm        = n_asm;
                        endcase
                        bip_inc = n_bip + 5'd1;
                        n_bip   = bip_inc;
                        if (bip_inc >= r_pix_bytes) begin
                            n_bip = '0;
                            if (n_sidx < tofp_pkg::COUNT_MAX) begin
                                if (i_width_sel == tofp_pkg::WSEL_32) begin
                                    idx = {n_sidx[10:5], odd, n_sidx[4:0]};
                                end else begin
                                    idx = {1'b0, n_sidx};
                                end
                                if (idx < ZONE_LIMIT) begin
                                    o_res.valid        = 1'b1;
                                    o_res.kind         = tofp_pkg::KIND_PIXEL;
                                    o_res.grid_index   = idx[10:0];
                                    o_res.odd_subframe = odd;
                                    if (r_layout[3:0] == tofp_pkg::LAYOUT_CONF) begin
                                        o_res.dist_mm    = n_asm[15:2];
                                        o_res.confidence = n_asm[23:16];
                                    end
                                    if (r_count < tofp_pkg::COUNT_MAX) begin
                                        n_count = r_count + 11'd1;
                                    end
                                end
                                n_sidx = n_sidx + 11'd1;
                            end
                        end
                        n_payload = r_payload - 16'd1;
                    end else if (r_payload <= 16'd1) begin
                        n_payload            = '0;
                        o_res.valid          = 1'b1;
                        o_res.kind           = tofp_pkg::KIND_STATUS;
                        o_res.frame_status   = (n_ems == tofp_pkg::END_MARK) ?
                                               tofp_pkg::ST_OK : tofp_pkg::ST_BAD_END;
                        o_res.pixel_count    = r_count;
                        o_res.frame_complete = (n_ems == tofp_pkg::END_MARK) && full;
                        o_res.odd_subframe   = odd;
                        n_aborted            = 1'b1;
                    end else begin
                        n_payload = r_payload - 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= '0;
            r_layout    <= '0;
            r_payload   <= '0;
            r_pix_bytes <= '0;
            r_bip       <= '0;
            r_asm       <= '0;
            r_sidx      <= '0;
            r_count     <= '0;
            r_ems       <= '0;
            r_aborted   <= 1'b1;
        end else begin
            r_byte_pos  <= n_byte_pos;
            r_layout    <= n_layout;
            r_payload   <= n_payload;
            r_pix_bytes <= n_pix_bytes;
            r_bip       <= n_bip;
            r_asm       <= n_asm;
            r_sidx      <= n_sidx;
            r_count     <= n_count;
            r_ems       <= n_ems;
            r_aborted   <= n_aborted;
        end
    end

    a_body_size_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_aborted && r_byte_pos == 5'(tofp_pkg::HDR_LEN)) |-> (r_pix_bytes >= 5'd3))
        else $error("body entered without a valid pixel size");

    a_bip_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_aborted && r_byte_pos == 5'(tofp_pkg::HDR_LEN)) |-> (r_bip < r_pix_bytes))
        else $error("byte in pixel ran past the pixel size");

    a_body_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_aborted && r_byte_pos == 5'(tofp_pkg::HDR_LEN)) |-> (r_payload != 16'd0))
        else $error("open frame body with no bytes left");

    a_status_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && o_res.valid && o_res.kind == tofp_pkg::KIND_STATUS) |=> r_aborted)
        else $error("frame still open after its status word");

endmodule

`default_nettype wire

/* design/tof_result_frame_parser.sv */
// ----------------------------------------------------------------------------
// tof_result_frame_parser
// Parses the byte stream of depth-sensor result frames into pixel words and
// at most one status word per frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  s_axis    in         tdata: data_byte; tuser: frame_start
//  m_axis    out        tdata: pixel or status fields; tuser: item_kind
//  cfg       in         grid_width_select (2 bits), no address
//
// One input word per cycle is sustained while the output is not stalled;
// each word is held in the input register, then its result in the output
// register. The frame state update between those registers sets the rate.
// Reset is synchronous and active low; no frame is open after reset until a
// word with frame_start arrives. A stalled output holds the input register,
// and the input register drains whenever the output register is free.
`default_nettype none

module tof_result_frame_parser #(
    parameter int unsigned MAX_ZONES = 1536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] frame_start

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [10:0] grid_index, [24:11] dist_mm, [32:25] confidence,
    // [34:33] frame_status, [45:35] pixel_count, [46] frame_complete,
    // [47] odd_subframe
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tuser,   // [0] item_kind

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data
);

    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_in_start;
    logic              r_out_vld;
    tofp_pkg::t_result r_out;
    logic [1:0]        r_width_sel;
    logic              advance;
    tofp_pkg::t_result res;

    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_sel <= 2'(tofp_pkg::WSEL_16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_width_sel <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser;
        end
    end

    tofp_parser #(
        .MAX_ZONES (MAX_ZONES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (advance),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_width_sel (r_width_sel),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= res.valid;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {r_out.odd_subframe, r_out.frame_complete, r_out.pixel_count,
                            r_out.frame_status, r_out.confidence, r_out.dist_mm,
                            r_out.grid_index};

    a_pixel_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == tofp_pkg::KIND_PIXEL)
            |-> (m_axis_tdata[46:33] == 14'd0))
        else $error("pixel word carries status fields");

    a_status_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == tofp_pkg::KIND_STATUS)
            |-> (m_axis_tdata[32:0] == 33'd0))
        else $error("status word carries pixel fields");

    a_complete_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[46]) |-> (m_axis_tdata[34:33] == tofp_pkg::ST_OK))
        else $error("frame complete flagged on a bad frame");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !advance) |=> (r_in_vld && $stable(r_in_byte) && $stable(r_in_start)))
        else $error("input word lost while the output was stalled");

endmodule

`default_nettype wire

/* tb/tof_result_frame_parser_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tof_result_frame_parser_test
// Self-checking testbench of the depth-sensor result frame parser. Byte
// streams of frames, some cut short, and noise bytes are queued per grid
// width setting and sent with random gaps while the output side stalls at
// random. A testbench frame model predicts every pixel and status word.
// Each received word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module tof_result_frame_parser_test;

    localparam int          ZONE_LIMIT   = 1536;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          MAX_REPORTS  = 40;
    localparam logic [1:0]  WSEL_SPARE   = 2'd3;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } t_stream_byte;

    typedef struct packed {
        tofp_pkg::t_kind   kind;
        logic [10:0]       grid_index;
        logic [13:0]       dist_mm;
        logic [7:0]        confidence;
        tofp_pkg::t_status frame_status;
        logic [10:0]       pixel_count;
        logic              frame_complete;
        logic              odd_subframe;
    } t_frame_word;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data    = 2'd0;

    t_stream_byte byte_q[$];
    t_frame_word  want_q[$];
    t_stream_byte nxt_byte;
    int           bytes_queued = 0;
    int           bytes_sent   = 0;
    int           err_cnt      = 0;
    int           src_hold     = 0;
    int           sink_hold    = 0;
    int           calm_left    = 0;
    int           stuck        = 0;

    // Frame model state.
    logic [1:0]   width_sel  = tofp_pkg::WSEL_16;
    int           hdr_pos    = 0;
    logic [7:0]   layout_reg = 8'h00;
    logic [15:0]  body_left  = 16'h0000;
    logic [4:0]   pix_size   = 5'd0;
    logic [4:0]   pix_byte   = 5'd0;
    logic [23:0]  pix_asm    = 24'h000000;
    logic [10:0]  sub_idx    = 11'd0;
    logic [10:0]  stored_cnt = 11'd0;
    logic [15:0]  end_shift  = 16'h0000;
    logic         frame_idle = 1'b1;

    tof_result_frame_parser #(
        .MAX_ZONES(ZONE_LIMIT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pixel_size(input logic [7:0] layout);
        return int'(layout[2:0]) * (layout[3] ? 5 : 3);
    endfunction

    function automatic int zone_width();
        if (width_sel == tofp_pkg::WSEL_16) return 16;
        if (width_sel == tofp_pkg::WSEL_32) return 32;
        return 8;
    endfunction

    function automatic int idle_gap();
        int r;
        if (calm_left > 0) return 0;
        r = $urandom_range(0, 999);
        if (r < 550) return 0;
        if (r < 900) return $urandom_range(1, 3);
        if (r < 985) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic emit_status(input tofp_pkg::t_status st, input logic odd);
        t_frame_word w;
        int zw;
        zw = zone_width();
        w.kind           = tofp_pkg::KIND_STATUS;
        w.grid_index     = '0;
        w.dist_mm        = '0;
        w.confidence     = '0;
        w.frame_status   = st;
        w.pixel_count    = stored_cnt;
        w.frame_complete = (st == tofp_pkg::ST_OK) && (int'(stored_cnt) == zw * zw);
        w.odd_subframe   = odd;
        want_q.push_back(w);
        frame_idle = 1'b1;
    endtask

    task automatic emit_pixel();
        t_frame_word w;
        int zw, row, col, idx;
        logic odd;
        zw  = zone_width();
        odd = |layout_reg[7:4];
        if (sub_idx < tofp_pkg::COUNT_MAX) begin
            row = int'(sub_idx) / zw;
            col = int'(sub_idx) % zw;
            if (zw == 32) row = row * 2 + int'(odd);
            idx = row * zw + col;
            if (idx < ZONE_LIMIT) begin
                w.kind           = tofp_pkg::KIND_PIXEL;
                w.grid_index     = 11'(idx);
                w.dist_mm        = '0;
                w.confidence     = '0;
                if (layout_reg[3:0] == tofp_pkg::LAYOUT_CONF) begin
                    w.dist_mm    = pix_asm[15:2];
                    w.confidence = pix_asm[23:16];
                end
                w.frame_status   = tofp_pkg::ST_OK;
                w.pixel_count    = '0;
                w.frame_complete = 1'b0;
                w.odd_subframe   = odd;
                want_q.push_back(w);
                if (stored_cnt < tofp_pkg::COUNT_MAX) stored_cnt = stored_cnt + 11'd1;
            end
            sub_idx = sub_idx + 11'd1;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic fs);
        int pos, payload, size;
        if (fs) begin
            frame_idle = 1'b0;
            hdr_pos    = 0;
            pix_byte   = '0;
            pix_asm    = '0;
            sub_idx    = '0;
            end_shift  = '0;
        end
        if (frame_idle) return;
        if (hdr_pos < tofp_pkg::HDR_LEN) begin
            pos     = hdr_pos;
            hdr_pos = hdr_pos + 1;
            if (pos == tofp_pkg::POS_ID) begin
                if (b[7:4] != tofp_pkg::FRAME_ID) emit_status(tofp_pkg::ST_BAD_ID, 1'b0);
            end else if (pos == tofp_pkg::POS_LAYOUT) begin
                layout_reg = b;
                if (b[7:4] == 4'h0) stored_cnt = '0;
            end else if (pos == tofp_pkg::POS_LEN_LO) begin
                body_left = {8'h00, b};
            end else if (pos == tofp_pkg::POS_LEN_HI) begin
                payload = int'({b, body_left[7:0]});
                size    = pixel_size({4'h0, layout_reg[3:0]});
                if (payload < tofp_pkg::MIN_PAYLOAD || size == 0 || size > 31) begin
                    emit_status(tofp_pkg::ST_BAD_LEN, |layout_reg[7:4]);
                end else begin
                    body_left = 16'(payload - tofp_pkg::FOOTER_LEN);
                    pix_size  = 5'(size);
                end
            end
            return;
        end
        end_shift = {b, end_shift[15:8]};
        if (body_left > tofp_pkg::FOOTER_LEN) begin
            if (pix_byte == 0) pix_asm = '0;
            if (pix_byte < 3) pix_asm[8 * pix_byte +: 8] = b;
            pix_byte = pix_byte + 5'd1;
            if (pix_byte >= pix_size) begin
                pix_byte = '0;
                emit_pixel();
            end
            body_left = body_left - 16'd1;
        end else if (body_left <= 1) begin
            body_left = '0;
            emit_status((end_shift == tofp_pkg::END_MARK) ? tofp_pkg::ST_OK
                                                          : tofp_pkg::ST_BAD_END,
                        |layout_reg[7:4]);
        end else begin
            body_left = body_left - 16'd1;
        end
    endtask

    task automatic push_byte(input logic [7:0] data, input logic start);
        t_stream_byte sb;
        sb.start = start;
        sb.data  = data;
        byte_q.push_back(sb);
        bytes_queued++;
    endtask

    task automatic queue_noise(input int n);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // A negative payload_ovr derives the length from the pixel count, a
    // negative cut sends the whole frame and a negative fill gives random bytes.
    task automatic queue_frame(input logic [7:0] id, input logic [7:0] layout, input int n_pix,
                               input int extra, input int payload_ovr, input bit good_end,
                               input int cut, input int fill);
        t_stream_byte fq[$];
        t_stream_byte sb;
        int size, payload, body, n;
        bit hdr_ok;
        size    = pixel_size({4'h0, layout[3:0]});
        payload = (payload_ovr >= 0) ? payload_ovr
                                     : tofp_pkg::MIN_PAYLOAD + n_pix * size + extra;
        hdr_ok  = (id[7:4] == tofp_pkg::FRAME_ID) && (payload >= tofp_pkg::MIN_PAYLOAD)
                  && (size > 0) && (size < 32);
        for (int i = 0; i < tofp_pkg::HDR_LEN; i++) begin
            sb.start = (i == 0);
            sb.data  = 8'($urandom_range(0, 255));
            if (i == tofp_pkg::POS_ID)     sb.data = id;
            if (i == tofp_pkg::POS_LAYOUT) sb.data = layout;
            if (i == tofp_pkg::POS_LEN_LO) sb.data = payload[7:0];
            if (i == tofp_pkg::POS_LEN_HI) sb.data = payload[15:8];
            fq.push_back(sb);
        end
        if (hdr_ok) begin
            body = payload - tofp_pkg::FOOTER_LEN;
            for (int j = 0; j < body; j++) begin
                sb.start = 1'b0;
                sb.data  = (fill >= 0) ? 8'(fill) : 8'($urandom_range(0, 255));
                if (j == body - 2)
                    sb.data = good_end ? 8'(tofp_pkg::END_MARK) : 8'(tofp_pkg::END_MARK >> 8);
                if (j == body - 1)
                    sb.data = good_end ? 8'(tofp_pkg::END_MARK >> 8) : 8'(tofp_pkg::END_MARK);
                fq.push_back(sb);
            end
        end
        n = (cut >= 0 && cut < fq.size()) ? cut : fq.size();
        for (int k = 0; k < n; k++) push_byte(fq[k].data, fq[k].start);
    endtask

    task automatic queue_random_frame();
        int r, n_pix, extra, size;
        logic [3:0] hi, lo;
        logic [7:0] id, layout;
        r  = $urandom_range(0, 99);
        id = {tofp_pkg::FRAME_ID, 4'($urandom_range(0, 15))};
        hi = ($urandom_range(0, 1) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
        if ($urandom_range(0, 1) == 0) begin
            lo = tofp_pkg::LAYOUT_CONF;
        end else begin
            do lo = 4'($urandom_range(0, 15));
            while (pixel_size({4'h0, lo}) == 0 || pixel_size({4'h0, lo}) > 31);
        end
        n_pix = $urandom_range(0, 12);
        if ($urandom_range(0, 9) == 0) begin
            n_pix = $urandom_range(40, 90);
            lo    = tofp_pkg::LAYOUT_CONF;
        end
        layout = {hi, lo};
        size   = pixel_size(layout);
        extra  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, size - 1);
        if (r < 70) begin
            queue_frame(id, layout, n_pix, extra, -1, 1'b1, -1, -1);
        end else if (r < 78) begin
            queue_frame(id, layout, n_pix, extra, -1, 1'b0, -1, -1);
        end else if (r < 83) begin
            do hi = 4'($urandom_range(0, 15));
            while (hi == tofp_pkg::FRAME_ID);
            queue_frame({hi, id[3:0]}, layout, n_pix, extra, -1, 1'b1, -1, -1);
        end else if (r < 88) begin
            if ($urandom_range(0, 1) == 0) begin
                queue_frame(id, layout, 0, 0, $urandom_range(0, tofp_pkg::MIN_PAYLOAD - 1),
                            1'b1, -1, -1);
            end else begin
                r  = $urandom_range(0, 2);
                lo = (r == 0) ? 4'h0 : ((r == 1) ? 4'h8 : 4'hF);
                queue_frame(id, {hi, lo}, 0, 0, $urandom_range(0, 65535), 1'b1, -1, -1);
            end
        end else if (r < 95) begin
            queue_frame(id, layout, n_pix, extra, -1, 1'b1, $urandom_range(1, 60), -1);
        end else begin
            queue_noise($urandom_range(1, 6));
        end
    endtask

    task automatic queue_random_phase(input int budget);
        int mark;
        mark = bytes_queued;
        while (bytes_queued - mark < budget) queue_random_frame();
        queue_frame({tofp_pkg::FRAME_ID, 4'h3}, {4'h0, tofp_pkg::LAYOUT_CONF}, 4, 0, -1,
                    1'b1, -1, -1);
    endtask

    task automatic drain();
        while (bytes_sent != bytes_queued || want_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [1:0] sel);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= sel;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        width_sel = sel;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        if (err_cnt < MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic check_word();
        t_frame_word w;
        if (want_q.size() == 0) begin
            report_mismatch("output word with no prediction pending");
            return;
        end
        w = want_q.pop_front();
        check_field("item_kind", 16'(m_axis_tuser), 16'(w.kind));
        check_field("grid_index", 16'(m_axis_tdata[10:0]), 16'(w.grid_index));
        check_field("dist_mm", 16'(m_axis_tdata[24:11]), 16'(w.dist_mm));
        check_field("confidence", 16'(m_axis_tdata[32:25]), 16'(w.confidence));
        check_field("frame_status", 16'(m_axis_tdata[34:33]), 16'(w.frame_status));
        check_field("pixel_count", 16'(m_axis_tdata[45:35]), 16'(w.pixel_count));
        check_field("frame_complete", 16'(m_axis_tdata[46]), 16'(w.frame_complete));
        check_field("odd_subframe", 16'(m_axis_tdata[47]), 16'(w.odd_subframe));
    endtask

    always @(posedge i_clk) begin
        if (calm_left > 0) begin
            calm_left <= calm_left - 1;
        end else if ($urandom_range(0, 499) == 0) begin
            calm_left <= $urandom_range(100, 400);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata, s_axis_tuser);
                bytes_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_hold > 0) begin
                    src_hold--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    nxt_byte = byte_q.pop_front();
                    s_axis_tdata  <= nxt_byte.data;
                    s_axis_tuser  <= nxt_byte.start;
                    s_axis_tvalid <= 1'b1;
                    src_hold = idle_gap();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_word();
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                sink_hold = idle_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stuck <= 0;
        end else if (stuck >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset width of 16, short directed frames.
        queue_noise(4);
        queue_frame(8'h10, 8'h01, 0, 0, -1, 1'b1, -1, -1);
        queue_frame(8'h1F, 8'h01, 2, 0, -1, 1'b1, -1, 8'hFF);
        queue_frame(8'h10, 8'h01, 1, 0, -1, 1'b1, -1, 8'h00);
        queue_frame(8'hEF, 8'h01, 1, 0, -1, 1'b1, -1, -1);
        queue_frame(8'h10, 8'h01, 0, 0, tofp_pkg::MIN_PAYLOAD - 1, 1'b1, -1, -1);
        queue_frame(8'h10, 8'h00, 0, 0, 16'hFFFF, 1'b1, -1, -1);
        queue_frame(8'h10, 8'hFF, 0, 0, 16'h0100, 1'b1, -1, -1);
        queue_frame(8'h10, 8'h0E, 2, 29, -1, 1'b1, -1, -1);
        queue_frame(8'h10, 8'h87, 1, 0, -1, 1'b1, -1, -1);
        queue_frame(8'h10, 8'h01, 3, 0, -1, 1'b0, -1, -1);
        queue_frame(8'h10, 8'h01, 5, 0, -1, 1'b1, 30, -1);
        queue_frame(8'h10, 8'h01, 3, 1, -1, 1'b1, -1, -1);
        queue_noise(3);
        queue_random_phase(20);
        drain();

        // Width 8: a complete grid.
        write_width(tofp_pkg::WSEL_8);
        queue_frame(8'h10, 8'h01, 64, 0, -1, 1'b1, -1, -1);
        queue_random_phase(10);
        drain();

        // Width 32: short even and odd subframes.
        write_width(tofp_pkg::WSEL_32);
        queue_frame(8'h10, 8'h01, 4, 0, -1, 1'b1, -1, -1);
        queue_frame(8'h10, 8'h31, 4, 0, -1, 1'b1, -1, -1);
        queue_random_phase(10);
        drain();

        write_width(WSEL_SPARE);
        queue_random_phase(20);
        drain();

        write_width(tofp_pkg::WSEL_16);
        queue_random_phase(20);
        drain();

        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/tofp_pkg.sv
design/tofp_parser.sv
design/tof_result_frame_parser.sv
tb/tof_result_frame_parser_test.sv
